/* sv/rwf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Replay window filter package
// Verdict codes shared by the filter and its port checker.
// ----------------------------------------------------------------------------
package rwf_pkg;

    typedef enum logic [1:0] {
        VERDICT_ACCEPTED = 2'd0,
        VERDICT_REJECTED = 2'd1,
        VERDICT_REPLAY   = 2'd2
    } verdict_t;

    localparam int unsigned SEQ_W   = 32;
    localparam int unsigned COUNT_W = 32;

endpackage : rwf_pkg
`default_nettype wire

/* sv/rwf_window.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Anti-replay sliding window
// Holds the highest sequence number and the bitmap of recent sequences,
// reports whether a sequence is fresh and commits it when told to.
// ----------------------------------------------------------------------------
module rwf_window
    import rwf_pkg::*;
#(
    parameter int unsigned WINDOW_BITS = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [SEQ_W-1:0] seq,
    input  wire logic             commit_en,
    output logic                  fresh
);

    localparam int unsigned IDX_W = $clog2(WINDOW_BITS);
    localparam logic [WINDOW_BITS-1:0] BIT_ZERO = {{(WINDOW_BITS-1){1'b0}}, 1'b1};
    localparam logic [SEQ_W-1:0] WIN_SIZE = SEQ_W'(WINDOW_BITS);

    logic                   seen_reg;
    logic [SEQ_W-1:0]       highest_reg;
    logic [WINDOW_BITS-1:0] bitmap_reg;
    logic [WINDOW_BITS-1:0] bitmap_next;

    logic [SEQ_W-1:0] behind;
    logic [SEQ_W-1:0] ahead;
    logic             is_ahead;
    logic             in_window;
    logic             far_ahead;
    logic             hit;

    assign behind    = highest_reg - seq;
    assign ahead     = seq - highest_reg;
    assign is_ahead  = behind[SEQ_W-1];
    assign in_window = !behind[SEQ_W-1] && (behind < WIN_SIZE);
    assign far_ahead = !(ahead < WIN_SIZE);
    assign hit       = in_window && bitmap_reg[behind[IDX_W-1:0]];
    assign fresh     = !seen_reg || is_ahead || (in_window && !hit);

    always_comb begin
        bitmap_next = bitmap_reg;
        if (!seen_reg) begin
            bitmap_next = BIT_ZERO;
        end else if (is_ahead) begin
            if (far_ahead) begin
                bitmap_next = BIT_ZERO;
            end else begin
                bitmap_next = (bitmap_reg << ahead[IDX_W-1:0]) | BIT_ZERO;
            end
        end else if (in_window) begin
            bitmap_next = bitmap_reg | (BIT_ZERO << behind[IDX_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= 1'b0;
            highest_reg <= '0;
            bitmap_reg  <= '0;
        end else if (commit_en) begin
            seen_reg   <= 1'b1;
            bitmap_reg <= bitmap_next;
            if (!seen_reg || is_ahead) begin
                highest_reg <= seq;
            end
        end
    end

endmodule : rwf_window
`default_nettype wire

/* sv/replay_window_filter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// A packet is held in the input register, and its result moves to the output register when the output is free.
// Throughput: one packet per cycle while m_ready does not stall the output; the window check is combinational.
// The window state is updated as an accepted packet moves to the output register, so the next one sees it.
// Reset is synchronous and active low; it clears the window, counters and keys_reg.
// ----------------------------------------------------------------------------
// Replay window filter
// Classifies received packets as accepted, rejected or replayed using a
// sliding anti-replay window, and keeps running counts of each verdict.
// ----------------------------------------------------------------------------
module replay_window_filter_unit
    import rwf_pkg::*;
#(
    parameter int unsigned WINDOW_BITS = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [SEQ_W-1:0]   s_sequence_req,
    input  wire logic               s_length_ok,
    input  wire logic               s_auth_ok,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_verdict,
    output logic [COUNT_W-1:0]      m_accepted_count,
    output logic [COUNT_W-1:0]      m_replay_count,
    output logic [COUNT_W-1:0]      m_rejected_count
);

    logic             keys_reg;

    logic             in_valid_reg;
    logic [SEQ_W-1:0] in_seq_reg;
    logic             in_len_reg;
    logic             in_auth_reg;

    logic             out_valid_reg;
    verdict_t         verdict_reg;
    verdict_t         verdict_next;

    logic [COUNT_W-1:0] accepted_reg;
    logic [COUNT_W-1:0] replay_reg;
    logic [COUNT_W-1:0] rejected_reg;

    logic advance;
    logic fresh;
    logic commit_en;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    rwf_window #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seq       (in_seq_reg),
        .commit_en (commit_en),
        .fresh     (fresh)
    );

    always_comb begin
        if (!keys_reg || !in_len_reg) begin
            verdict_next = VERDICT_REJECTED;
        end else if (!fresh) begin
            verdict_next = VERDICT_REPLAY;
        end else if (!in_auth_reg) begin
            verdict_next = VERDICT_REJECTED;
        end else begin
            verdict_next = VERDICT_ACCEPTED;
        end
    end

    assign commit_en = advance && (verdict_next == VERDICT_ACCEPTED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keys_reg <= 1'b0;
        end else if (cfg_we) begin
            keys_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_seq_reg  <= s_sequence_req;
            in_len_reg  <= s_length_ok;
            in_auth_reg <= s_auth_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            accepted_reg  <= '0;
            replay_reg    <= '0;
            rejected_reg  <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                case (verdict_next)
                    VERDICT_ACCEPTED: accepted_reg <= accepted_reg + COUNT_W'(1);
                    VERDICT_REPLAY:   replay_reg   <= replay_reg + COUNT_W'(1);
                    default:          rejected_reg <= rejected_reg + COUNT_W'(1);
                endcase
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            verdict_reg <= verdict_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_verdict        = verdict_reg;
    assign m_accepted_count = accepted_reg;
    assign m_replay_count   = replay_reg;
    assign m_rejected_count = rejected_reg;

endmodule : replay_window_filter_unit
`default_nettype wire

/* sv/rwf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Replay window filter port checker
// Watches the ports of the filter and checks reset, stall and counter rules.
// ----------------------------------------------------------------------------
module rwf_checker
    import rwf_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [1:0]         m_verdict,
    input wire logic [COUNT_W-1:0] m_accepted_count,
    input wire logic [COUNT_W-1:0] m_replay_count,
    input wire logic [COUNT_W-1:0] m_rejected_count
);

    logic [COUNT_W-1:0] count_sum;

    assign count_sum = m_accepted_count + m_replay_count + m_rejected_count;

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && (count_sum == '0))
        else $error("Result valid or counters nonzero after reset.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_verdict) && $stable(count_sum))
        else $error("Result changed while stalled.");

    a_one_count_per_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(m_valid && m_ready) && m_valid |-> count_sum == $past(count_sum) + COUNT_W'(1))
        else $error("Counters did not advance by exactly one per packet.");

    a_accept_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(m_valid && m_ready) && m_valid && (m_verdict == VERDICT_ACCEPTED)
        |-> m_accepted_count == $past(m_accepted_count) + COUNT_W'(1))
        else $error("Accepted packet not counted as accepted.");

    a_replay_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(m_valid && m_ready) && m_valid && (m_verdict == VERDICT_REPLAY)
        |-> m_replay_count == $past(m_replay_count) + COUNT_W'(1))
        else $error("Replayed packet not counted as a replay.");

endmodule : rwf_checker

bind replay_window_filter_unit rwf_checker u_rwf_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_verdict        (m_verdict),
    .m_accepted_count (m_accepted_count),
    .m_replay_count   (m_replay_count),
    .m_rejected_count (m_rejected_count)
);
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay window filter testbench
// Drives packets through the valid/ready input with random gaps and stalls
// the result channel at random. A scoreboard predicts every verdict and the
// three running counters from its own copy of the anti-replay window. Results
// are checked in order, field by field, with keys both loaded and not loaded.
// ----------------------------------------------------------------------------
module testbench;
    import rwf_pkg::*;

    localparam int unsigned WIN            = 64;
    localparam int unsigned TIMEOUT_CYCLES = 400000;
    localparam int unsigned PHASE_ITEMS    = 205;

    typedef struct {
        logic [SEQ_W-1:0] seq;
        logic             len_ok;
        logic             auth_ok;
    } packet_t;

    typedef struct {
        verdict_t           verdict;
        logic [COUNT_W-1:0] acc;
        logic [COUNT_W-1:0] rep;
        logic [COUNT_W-1:0] rej;
    } verdict_rec_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_wdata = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [SEQ_W-1:0]   s_sequence_req = '0;
    logic               s_length_ok = 1'b0;
    logic               s_auth_ok = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_verdict;
    logic [COUNT_W-1:0] m_accepted_count;
    logic [COUNT_W-1:0] m_replay_count;
    logic [COUNT_W-1:0] m_rejected_count;

    packet_t      packet_q[$];
    verdict_rec_t verdict_q[$];

    int unsigned n_queued = 0;
    int unsigned n_sent = 0;
    int unsigned n_errors = 0;
    int unsigned cycle_count = 0;
    logic        s_took = 1'b0;
    bit          calm = 1'b0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;

    // Scoreboard copy of the window and counters.
    logic               keys_on;
    logic               win_seen;
    logic [SEQ_W-1:0]   win_top;
    logic [63:0]        win_map;
    logic [COUNT_W-1:0] cnt_acc;
    logic [COUNT_W-1:0] cnt_rep;
    logic [COUNT_W-1:0] cnt_rej;

    replay_window_filter_unit #(
        .WINDOW_BITS(WIN)
    ) DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sequence_req   (s_sequence_req),
        .s_length_ok      (s_length_ok),
        .s_auth_ok        (s_auth_ok),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_verdict        (m_verdict),
        .m_accepted_count (m_accepted_count),
        .m_replay_count   (m_replay_count),
        .m_rejected_count (m_rejected_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic verdict_rec_t classify_packet(packet_t p);
        logic signed [31:0] lag;
        longint             d;
        logic               fresh;
        logic [63:0]        mask;
        verdict_rec_t       r;
        mask = (WIN >= 64) ? '1 : ((64'd1 << WIN) - 64'd1);
        lag = win_top - p.seq;
        d = lag;
        if (!win_seen) fresh = 1'b1;
        else if (d < 0) fresh = 1'b1;
        else if (d >= WIN) fresh = 1'b0;
        else fresh = !win_map[int'(d)];

        if (!keys_on || !p.len_ok) begin
            cnt_rej = cnt_rej + 1;
            r.verdict = VERDICT_REJECTED;
        end else if (!fresh) begin
            cnt_rep = cnt_rep + 1;
            r.verdict = VERDICT_REPLAY;
        end else if (!p.auth_ok) begin
            cnt_rej = cnt_rej + 1;
            r.verdict = VERDICT_REJECTED;
        end else begin
            if (!win_seen) begin
                win_seen = 1'b1;
                win_top = p.seq;
                win_map = 64'd1;
            end else if (d < 0) begin
                if (-d >= WIN) win_map = 64'd1;
                else win_map = ((win_map << int'(-d)) | 64'd1) & mask;
                win_top = p.seq;
            end else if (d < WIN) begin
                win_map[int'(d)] = 1'b1;
            end
            cnt_acc = cnt_acc + 1;
            r.verdict = VERDICT_ACCEPTED;
        end
        r.acc = cnt_acc;
        r.rep = cnt_rep;
        r.rej = cnt_rej;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        n_errors++;
    endtask

    // Driver: a new packet is presented only after the previous transfer.
    always @(negedge aclk) begin
        packet_t p;
        if (s_valid && !s_took) begin
        end else if (send_gap > 0) begin
            s_valid <= 1'b0;
            send_gap--;
        end else if (packet_q.size() > 0) begin
            p = packet_q.pop_front();
            s_sequence_req <= p.seq;
            s_length_ok <= p.len_ok;
            s_auth_ok <= p.auth_ok;
            s_valid <= 1'b1;
            send_gap = pick_gap();
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (recv_stall > 0) begin
            m_ready <= 1'b0;
            recv_stall--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_stall = pick_gap();
        end
    end

    // Monitor: check the output transfer first, then predict the input one.
    always @(posedge aclk) begin
        packet_t      p;
        verdict_rec_t want;
        cycle_count++;
        s_took <= s_valid && s_ready;
        if (!aresetn) begin
            keys_on = 1'b0;
            win_seen = 1'b0;
            win_top = '0;
            win_map = '0;
            cnt_acc = '0;
            cnt_rep = '0;
            cnt_rej = '0;
        end else begin
            if (cfg_we) keys_on = cfg_wdata;
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected result, verdict", 32'(m_verdict), 32'd0);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_verdict !== want.verdict)
                        report_mismatch("verdict", 32'(m_verdict), 32'(want.verdict));
                    if (m_accepted_count !== want.acc)
                        report_mismatch("accepted_count", m_accepted_count, want.acc);
                    if (m_replay_count !== want.rep)
                        report_mismatch("replay_count", m_replay_count, want.rep);
                    if (m_rejected_count !== want.rej)
                        report_mismatch("rejected_count", m_rejected_count, want.rej);
                end
            end
            if (s_valid && s_ready) begin
                p.seq = s_sequence_req;
                p.len_ok = s_length_ok;
                p.auth_ok = s_auth_ok;
                verdict_q.push_back(classify_packet(p));
                n_sent++;
            end
        end
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("timeout with %0d results outstanding", verdict_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_packet(logic [31:0] seq, logic len_ok, logic auth_ok);
        packet_t p;
        p.seq = seq;
        p.len_ok = len_ok;
        p.auth_ok = auth_ok;
        packet_q.push_back(p);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_sent != n_queued || verdict_q.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_keys(logic value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed traffic around a moving cursor, with jumps and noise.
    task automatic push_stream(int unsigned count);
        logic [31:0] cursor;
        logic [31:0] seq;
        int unsigned r;
        int unsigned sub;
        int          edge_offs[6];
        edge_offs = '{-65, -64, -63, 63, 64, 65};
        cursor = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom;
        repeat (count) begin
            r = $urandom_range(0, 99);
            sub = $urandom_range(0, 99);
            if (r < 8) begin
                push_packet($urandom, 1'($urandom), 1'($urandom));
            end else begin
                if (sub < 4) begin
                    cursor = cursor + $urandom;
                    seq = cursor;
                end else if (sub < 6) begin
                    cursor = cursor + 32'h8000_0000;
                    seq = cursor;
                end else if (sub < 10) begin
                    seq = cursor + 32'(edge_offs[$urandom_range(0, 5)]);
                end else begin
                    cursor = cursor + 32'($urandom_range(0, 3));
                    seq = cursor + 32'($urandom_range(0, 72)) - 32'd66;
                end
                push_packet(seq, $urandom_range(0, 19) != 0, $urandom_range(0, 9) != 0);
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Keys not loaded: everything is rejected.
        push_packet(32'h0000_0005, 1'b1, 1'b1);
        push_packet(32'h0000_0000, 1'b0, 1'b0);
        push_packet(32'hFFFF_FFFF, 1'b1, 1'b1);
        wait_drained();
        write_keys(1'b1);

        push_packet(32'hFFFF_FFFE, 1'b1, 1'b0);
        push_packet(32'hFFFF_FFFE, 1'b1, 1'b1);
        push_packet(32'hFFFF_FFFE, 1'b1, 1'b1);
        push_packet(32'hFFFF_FFFE, 1'b0, 1'b1);
        push_packet(32'h0000_0001, 1'b1, 1'b1);
        push_packet(32'hFFFF_FFFF, 1'b1, 1'b0);
        push_packet(32'hFFFF_FFFF, 1'b1, 1'b1);
        push_packet(32'hFFFF_FFFF, 1'b1, 1'b0);
        push_packet(32'h0000_0000, 1'b1, 1'b1);
        push_packet(32'hFFFF_FFC2, 1'b1, 1'b1);
        push_packet(32'hFFFF_FFC1, 1'b1, 1'b1);
        push_packet(32'h0000_0041, 1'b1, 1'b1);
        push_packet(32'h0000_0080, 1'b1, 1'b1);
        push_packet(32'h0000_0041, 1'b1, 1'b1);
        push_packet(32'h8000_0080, 1'b1, 1'b1);
        push_packet(32'h0000_0080, 1'b1, 1'b1);
        push_packet(32'h7FFF_FFFF, 1'b1, 1'b1);
        push_packet(32'hFFFF_FFFF, 1'b1, 1'b1);
        push_packet(32'h8000_0000, 1'b1, 1'b1);
        push_packet(32'hFFFF_FFFF, 1'b1, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 7; phase++) begin
            write_keys((phase == 2) ? 1'b0 : 1'b1);
            calm = (phase == 4);
            push_stream(PHASE_ITEMS);
            wait_drained();
        end

        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
